### hdl/sum_tree_weighted_event_sampler_unit_defines.svh
// Assertion macros for the sum tree event sampler checker.
// Used by stwes_checker only; needs i_clk and i_rst_n in scope.
`ifndef SUM_TREE_WEIGHTED_EVENT_SAMPLER_UNIT_DEFINES_SVH
`define SUM_TREE_WEIGHTED_EVENT_SAMPLER_UNIT_DEFINES_SVH

// same-cycle implication
`define STWES_AST_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STWES_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/stwes_pkg.sv
// Shared types and constants for the sum tree event sampler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package stwes_pkg;
    localparam int DEF_LEAVES      = 1024;
    localparam int DEF_WEIGHT_BITS = 32;
    localparam int IDX_W      = 10;
    localparam int RAND_W     = 32;
    localparam int TOTAL_W    = 42;
    localparam int COUNT_W    = 11;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 96;
    localparam int DIV_W      = 38;   // -ln(r2) in Q.32, at most 22.2
    localparam int IT_W       = 6;
    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_CLR,
        DP_LOAD,
        DP_LEAF_RD,
        DP_LEAF_WR,
        DP_SIB_RD,
        DP_PAR_WR,
        DP_MUL_LO,
        DP_MUL_HI,
        DP_CH_RD,
        DP_CH_STEP,
        DP_NORM,
        DP_SQ,
        DP_NL2,
        DP_NL_LO,
        DP_NL_HI,
        DP_DIV,
        DP_OUT_PLAIN,
        DP_OUT_EVT,
        DP_OUT_INF
    } t_dp_op;

    typedef struct packed {
        logic cmd;
        logic in_range;
        logic no_event;
        logic wait_zero;
        logic at_root;
        logic m_top;
        logic walk_last;
        logic sq_last;
        logic div_last;
        logic clr_last;
    } t_dp_status;
endpackage
`default_nettype wire

### hdl/stwes_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module stwes_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### hdl/stwes_datapath.sv
// Datapath: node memory, shared 32x32 multiplier, walk, log and divide registers.
// Depends on stwes_pkg and stwes_ram.
`timescale 1ns / 1ps
`default_nettype none
module stwes_datapath import stwes_pkg::*; #(
    parameter int LEAVES      = DEF_LEAVES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_op                i_op,
    input  wire logic                  i_cmd,
    input  wire logic [IN_DATA_W-1:0]  i_data,
    output t_dp_status                 o_st,
    output logic      [OUT_DATA_W-1:0] o_data,
    output logic                       o_occurred
);
    localparam int LVL      = $clog2(LEAVES);
    localparam int AW       = LVL + 1;
    localparam int DEPTH    = 2 ** AW;
    localparam int SUM_BITS = WEIGHT_BITS + LVL;
    localparam int CNT_W    = $clog2(LEAVES + 1);
    localparam int WK       = (WEIGHT_BITS < RAND_W) ? WEIGHT_BITS : RAND_W;

    // control registers
    logic [AW-1:0]       r_clr;
    logic [CNT_W-1:0]    r_count;
    logic [SUM_BITS-1:0] r_total;
    logic [IT_W-1:0]     r_it;
    // payload registers
    logic                r_cmd;
    logic [IDX_W-1:0]    r_idx;
    logic [SUM_BITS-1:0] r_w;
    logic [RAND_W-1:0]   r_rp;
    logic [AW-1:0]       r_node;
    logic [SUM_BITS-1:0] r_cur;
    logic [63:0]         r_prod;
    logic [4:0]          r_n;
    logic [31:0]         r_m;
    logic [31:0]         r_frac;
    logic [DIV_W-1:0]    r_nl2;
    logic [DIV_W-1:0]    r_dvd;
    logic [SUM_BITS-1:0] r_rem;
    logic [IDX_W-1:0]    r_o_idx;
    logic [31:0]         r_o_wait;
    logic                r_o_occ;
    logic [TOTAL_W-1:0]  r_o_total;
    logic [COUNT_W-1:0]  r_o_cnt;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [SUM_BITS-1:0] ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [SUM_BITS-1:0] ram_rdata;

    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         mul_p;
    logic [63:0]         t64;
    logic [32:0]         sq_s;
    logic [SUM_BITS:0]   div_t;
    logic [SUM_BITS:0]   div_d;
    logic                div_ge;
    logic [SUM_BITS-1:0] par_sum;
    logic [LVL-1:0]      leaf;
    logic [LVL-1:0]      leaf_c;
    logic                q_big;

    stwes_ram #(.WIDTH(SUM_BITS), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign t64     = 64'(r_total);
    assign mul_p   = 64'(mul_a) * 64'(mul_b);
    assign sq_s    = mul_p[63:31];
    assign div_t   = {r_rem, r_dvd[DIV_W-1]};
    assign div_ge  = div_t >= {1'b0, r_total};
    assign div_d   = div_t - {1'b0, r_total};
    assign par_sum = r_cur + ram_rdata;
    assign leaf    = r_node[LVL-1:0];
    assign leaf_c  = (32'(leaf) >= 32'(LEAVES)) ? LVL'(LEAVES - 1) : leaf;
    assign q_big   = |r_dvd[DIV_W-1:32];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_op)
            DP_MUL_LO: begin mul_a = r_rp;  mul_b = t64[31:0];  end
            DP_MUL_HI: begin mul_a = r_rp;  mul_b = t64[63:32]; end
            DP_SQ:     begin mul_a = r_m;   mul_b = r_m;        end
            DP_NL_LO:  begin mul_a = r_nl2[31:0]; mul_b = LN2_Q32; end
            DP_NL_HI:  begin mul_a = 32'(r_nl2[DIV_W-1:32]); mul_b = LN2_Q32; end
            default: ;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_node;
        ram_wdata = r_w;
        ram_raddr = r_node;
        case (i_op)
            DP_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            DP_LEAF_WR: ram_we = 1'b1;
            DP_SIB_RD:  ram_raddr = r_node ^ AW'(1);
            DP_PAR_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_node >> 1;
                ram_wdata = par_sum;
            end
            DP_CH_RD:   ram_raddr = {r_node[AW-2:0], 1'b0};
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_count <= '0;
            r_total <= '0;
            r_it    <= '0;
        end else begin
            case (i_op)
                DP_CLR:  r_clr <= r_clr + AW'(1);
                DP_LOAD: r_it  <= '0;
                DP_LEAF_WR:
                    r_count <= r_count - CNT_W'(ram_rdata != '0) + CNT_W'(r_w != '0);
                DP_PAR_WR:
                    if (r_node[AW-1:1] == (AW-1)'(1)) r_total <= par_sum;
                DP_CH_STEP:
                    r_it <= o_st.walk_last ? '0 : r_it + IT_W'(1);
                DP_SQ:
                    r_it <= o_st.sq_last ? '0 : r_it + IT_W'(1);
                DP_NL_HI: r_it <= '0;
                DP_DIV:
                    r_it <= o_st.div_last ? '0 : r_it + IT_W'(1);
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_op)
            DP_LOAD: begin
                r_cmd  <= i_cmd;
                r_idx  <= i_data[IDX_W-1:0];
                r_w    <= SUM_BITS'(i_data[IDX_W +: WK]);
                r_rp   <= i_data[IDX_W+RAND_W +: RAND_W];
                r_m    <= i_data[IDX_W+2*RAND_W +: RAND_W];
                r_n    <= 5'd31;
                r_node <= {1'b1, LVL'(i_data[IDX_W-1:0])};
            end
            DP_LEAF_WR: r_cur <= r_w;
            DP_PAR_WR: begin
                r_cur  <= par_sum;
                r_node <= r_node >> 1;
            end
            DP_MUL_LO: r_prod <= mul_p;
            DP_MUL_HI: begin
                r_cur  <= SUM_BITS'(64'(r_prod[63:32]) + mul_p);
                r_node <= AW'(1);
            end
            DP_CH_STEP: begin
                if (r_cur < ram_rdata) begin
                    r_node <= {r_node[AW-2:0], 1'b0};
                end else begin
                    r_cur  <= r_cur - ram_rdata;
                    r_node <= {r_node[AW-2:0], 1'b1};
                end
            end
            DP_NORM: begin
                r_m <= r_m << 1;
                r_n <= r_n - 5'd1;
            end
            DP_SQ: begin
                r_m    <= sq_s[32] ? sq_s[32:1] : sq_s[31:0];
                r_frac <= {r_frac[30:0], sq_s[32]};
            end
            DP_NL2:   r_nl2  <= (DIV_W'(32) << 32) - DIV_W'({r_n, r_frac});
            DP_NL_LO: r_prod <= mul_p;
            DP_NL_HI: begin
                r_dvd <= DIV_W'(r_prod[63:32]) + DIV_W'(mul_p);
                r_rem <= '0;
            end
            DP_DIV: begin
                r_rem <= div_ge ? div_d[SUM_BITS-1:0] : div_t[SUM_BITS-1:0];
                r_dvd <= {r_dvd[DIV_W-2:0], div_ge};
            end
            DP_OUT_PLAIN, DP_OUT_EVT, DP_OUT_INF: begin
                r_o_total <= TOTAL_W'(r_total);
                r_o_cnt   <= COUNT_W'(r_count);
                r_o_occ   <= (i_op != DP_OUT_PLAIN);
                r_o_idx   <= (i_op == DP_OUT_PLAIN) ? '0 : IDX_W'(leaf_c);
                if (i_op == DP_OUT_PLAIN) begin
                    r_o_wait <= '0;
                end else if (i_op == DP_OUT_INF || q_big) begin
                    r_o_wait <= '1;
                end else begin
                    r_o_wait <= r_dvd[31:0];
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_st.cmd       = r_cmd;
        o_st.in_range  = 32'(r_idx) < 32'(LEAVES);
        o_st.no_event  = (r_count == '0) || (r_total == '0);
        o_st.wait_zero = (r_m == '0);
        o_st.at_root   = (r_node == AW'(1));
        o_st.m_top     = r_m[31];
        o_st.walk_last = (r_it == IT_W'(LVL - 1));
        o_st.sq_last   = (r_it == IT_W'(31));
        o_st.div_last  = (r_it == IT_W'(DIV_W - 1));
        o_st.clr_last  = &r_clr;
    end

    assign o_data     = {1'b0, r_o_cnt, r_o_total, r_o_wait, r_o_idx};
    assign o_occurred = r_o_occ;
endmodule
`default_nettype wire

### hdl/stwes_controller.sv
// Controller state machine: sequences clear, update, draw, log and divide steps.
// Depends on stwes_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stwes_controller import stwes_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_dp_op          o_op,
    input  wire t_dp_status i_st
);
    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_LEAF_WR, S_UP_RD, S_UP_WR,
        S_MUL_HI, S_CH_RD, S_CH_STEP, S_NORM, S_SQ, S_NL2, S_NL_LO,
        S_NL_HI, S_DIV, S_FIN_PLAIN, S_FIN_EVT, S_FIN_INF
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_op        = DP_NOP;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_CLEAR: begin
                o_op = DP_CLR;
                if (i_st.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = DP_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_st.cmd) begin
                    if (i_st.in_range) begin
                        o_op    = DP_LEAF_RD;
                        n_state = S_LEAF_WR;
                    end else begin
                        n_state = S_FIN_PLAIN;
                    end
                end else if (i_st.no_event) begin
                    n_state = S_FIN_PLAIN;
                end else begin
                    o_op    = DP_MUL_LO;
                    n_state = S_MUL_HI;
                end
            end
            S_LEAF_WR: begin
                o_op    = DP_LEAF_WR;
                n_state = S_UP_RD;
            end
            S_UP_RD: begin
                if (i_st.at_root) begin
                    n_state = S_FIN_PLAIN;
                end else begin
                    o_op    = DP_SIB_RD;
                    n_state = S_UP_WR;
                end
            end
            S_UP_WR: begin
                o_op    = DP_PAR_WR;
                n_state = S_UP_RD;
            end
            S_MUL_HI: begin
                o_op    = DP_MUL_HI;
                n_state = S_CH_RD;
            end
            S_CH_RD: begin
                o_op    = DP_CH_RD;
                n_state = S_CH_STEP;
            end
            S_CH_STEP: begin
                o_op = DP_CH_STEP;
                if (!i_st.walk_last)    n_state = S_CH_RD;
                else if (i_st.wait_zero) n_state = S_FIN_INF;
                else                     n_state = S_NORM;
            end
            S_NORM: begin
                if (i_st.m_top) n_state = S_SQ;
                else            o_op    = DP_NORM;
            end
            S_SQ: begin
                o_op = DP_SQ;
                if (i_st.sq_last) n_state = S_NL2;
            end
            S_NL2: begin
                o_op    = DP_NL2;
                n_state = S_NL_LO;
            end
            S_NL_LO: begin
                o_op    = DP_NL_LO;
                n_state = S_NL_HI;
            end
            S_NL_HI: begin
                o_op    = DP_NL_HI;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_op = DP_DIV;
                if (i_st.div_last) n_state = S_FIN_EVT;
            end
            S_FIN_PLAIN, S_FIN_EVT, S_FIN_INF: begin
                if (out_free) begin
                    o_op        = (r_state == S_FIN_EVT) ? DP_OUT_EVT :
                                  (r_state == S_FIN_INF) ? DP_OUT_INF : DP_OUT_PLAIN;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule
`default_nettype wire

### hdl/sum_tree_weighted_event_sampler_unit.sv
// Top level of the sum tree weighted event sampler.
// Depends on stwes_pkg, stwes_controller, stwes_datapath (and stwes_ram below it).
//
// Weighted event sampler over a binary sum tree of LEAVES unsigned Q16.16
// weights. A set item (tuser 0) writes one leaf and rewrites its ancestors;
// a draw item (tuser 1) picks a leaf with probability proportional to its
// weight and returns -ln(r2)/total as a Q16.16 waiting time. Every item gives
// exactly one result. One item is in work at a time. Steps, with L =
// log2(LEAVES) tree levels (10 by default): a set item decodes, reads and
// writes the leaf, then reads each sibling and writes each parent up to the
// root; a draw item decodes, scales the pick by the total and walks down the
// L levels; if r2 is zero it then loads a saturated wait, else it normalizes
// r2 with left shifts, runs 32 squaring steps on the shared 32x32 multiplier,
// scales the log2 by ln2, runs 38 restoring divide steps and loads the output;
// a draw with no active weight, or a set outside the leaf range, goes straight
// to the output. The block returns to idle before it accepts the next item.
// After reset the node memory is cleared one entry a cycle, all 2*P entries
// with P the leaf count rounded up to a power of two (1024 by default), and
// no item is accepted until that pass ends. A finished result sits in the
// output register and does not block the next item from being accepted.
`timescale 1ns / 1ps
`default_nettype none
module sum_tree_weighted_event_sampler_unit import stwes_pkg::*; #(
    parameter int LEAVES      = DEF_LEAVES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [9:0] leaf_index, [41:10] new_weight, [73:42] random_pick,
    // [105:74] random_wait, [111:106] zero
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] command
    input  wire logic [0:0]            s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [9:0] event_index, [41:10] wait_time, [83:42] total_weight,
    // [94:84] active_count, [95] zero
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] event_occurred
    output logic      [0:0]            m_axis_tuser
);
    t_dp_op     op;
    t_dp_status st;

    stwes_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_op        (op),
        .i_st        (st)
    );

    stwes_datapath #(.LEAVES(LEAVES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op),
        .i_cmd      (s_axis_tuser[0]),
        .i_data     (s_axis_tdata),
        .o_st       (st),
        .o_data     (m_axis_tdata),
        .o_occurred (m_axis_tuser[0])
    );
endmodule
`default_nettype wire

### hdl/stwes_checker.sv
// Port-level checker for the sum tree event sampler, bound to the top level.
// Depends on sum_tree_weighted_event_sampler_unit_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sum_tree_weighted_event_sampler_unit_defines.svh"
module stwes_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [95:0]  m_axis_tdata,
    input wire logic [0:0]   m_axis_tuser
);
    `STWES_AST_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
    `STWES_AST_NXT(a_out_stable, m_axis_tvalid && !m_axis_tready,
        $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
    `STWES_AST_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "second item taken while busy")
    `STWES_AST_NOW(a_event_has_weight, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tdata[94:84] != 11'd0, "event with no active leaf")
    `STWES_AST_NOW(a_no_event_zero, m_axis_tvalid && !m_axis_tuser[0],
        (m_axis_tdata[9:0] == 10'd0) && (m_axis_tdata[41:10] == 32'd0),
        "no-event result carries index or wait")
endmodule

bind sum_tree_weighted_event_sampler_unit stwes_checker u_stwes_checker (.*);
`default_nettype wire

### dv/tb_top.sv
// Self-checking bench for sum_tree_weighted_event_sampler_unit: set and draw items,
// predicted against a local sum tree. Depends on stwes_pkg and the RTL under hdl.
`timescale 1ns / 1ps
module tb_top;
    import stwes_pkg::*;

    localparam int  N_LEAVES   = DEF_LEAVES;
    localparam int  PAD_LEAVES = 1024;          // N_LEAVES rounded up to a power of two
    localparam int  N_RANDOM   = 1630;
    localparam int  CYCLE_CAP  = 2_000_000;     // a longer run is reported as a mismatch
    localparam int  TAIL_WAIT  = 300;           // longest draw plus margin
    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_DRAW = 1'b1;
    localparam logic [63:0] LN2_FIX = 64'hB17217F8;
    localparam logic [63:0] SAT32   = 64'hFFFF_FFFF;

    typedef struct {
        logic [IDX_W-1:0]   event_index;
        logic [31:0]        wait_time;
        logic               event_occurred;
        logic [TOTAL_W-1:0] total_weight;
        logic [COUNT_W-1:0] active_count;
    } t_draw_result;

    // Tree model plus a queue of outstanding results.
    class sampler_scoreboard;
        logic [63:0]  node_sum [0:2*PAD_LEAVES-2];
        int unsigned  nonzero_leaves;
        t_draw_result pending_results [$];
        int unsigned  errors;

        function new();
            foreach (node_sum[i]) node_sum[i] = '0;
            nonzero_leaves = 0;
            errors = 0;
        endfunction

        // -ln(x / 2^32) in Q.32, x nonzero
        static function logic [63:0] neg_ln_fix(logic [31:0] x);
            int          msb;
            logic [63:0] mant, frac, log2v, nl2;
            msb = 31;
            frac = '0;
            while (!x[msb]) msb--;
            mant = 64'(x) << (31 - msb);
            for (int k = 31; k >= 0; k--) begin
                mant = (mant * mant) >> 31;
                if (mant >= (64'd2 << 31)) begin
                    mant = mant >> 1;
                    frac[k] = 1'b1;
                end
            end
            log2v = (64'(msb) << 32) | frac;
            nl2   = (64'd32 << 32) - log2v;
            return (((nl2 & SAT32) * LN2_FIX) >> 32) + (nl2 >> 32) * LN2_FIX;
        endfunction

        function void note_item(logic cmd, logic [IDX_W-1:0] leaf, logic [31:0] weight,
                                logic [31:0] r_pick, logic [31:0] r_wait);
            t_draw_result r;
            int unsigned  node, off;
            logic [63:0]  total, pick, q;
            off = PAD_LEAVES - 1;
            r.event_index = '0;
            r.wait_time = '0;
            r.event_occurred = 1'b0;
            if (cmd == CMD_SET) begin
                if (leaf < N_LEAVES) begin
                    node = off + leaf;
                    if (node_sum[node] != 0) nonzero_leaves--;
                    if (weight != 0) nonzero_leaves++;
                    node_sum[node] = 64'(weight);
                    while (node > 0) begin
                        node = (node - 1) / 2;
                        node_sum[node] = node_sum[2*node+1] + node_sum[2*node+2];
                    end
                end
            end else if (nonzero_leaves != 0 && node_sum[0] != 0) begin
                total = node_sum[0];
                // floor(r_pick * total / 2^32), split so nothing overflows
                pick = ((64'(r_pick) * (total & SAT32)) >> 32) + 64'(r_pick) * (total >> 32);
                node = 0;
                while (node < off) begin
                    if (pick < node_sum[2*node+1]) begin
                        node = 2*node + 1;
                    end else begin
                        pick -= node_sum[2*node+1];
                        node = 2*node + 2;
                    end
                end
                r.event_index = (node - off >= N_LEAVES) ? IDX_W'(N_LEAVES-1)
                                                         : IDX_W'(node - off);
                if (r_wait == 0) begin
                    r.wait_time = 32'hFFFF_FFFF;   // -ln(0) saturates
                end else begin
                    q = neg_ln_fix(r_wait) / total;
                    r.wait_time = (q > SAT32) ? 32'hFFFF_FFFF : q[31:0];
                end
                r.event_occurred = 1'b1;
            end
            r.total_weight = node_sum[0][TOTAL_W-1:0];
            r.active_count = COUNT_W'(nonzero_leaves);
            pending_results.push_back(r);
        endfunction

        task report(string field, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("%0t: %s got 0x%0h, expected 0x%0h", $realtime, field, got, want);
        endtask

        task check_result(logic [OUT_DATA_W-1:0] data, logic flag);
            t_draw_result r;
            if (pending_results.size() == 0) begin
                report("unexpected result", 64'(data), 64'd0);
            end else begin
                r = pending_results.pop_front();
                if (data[9:0] !== r.event_index)
                    report("event_index", 64'(data[9:0]), 64'(r.event_index));
                if (data[41:10] !== r.wait_time)
                    report("wait_time", 64'(data[41:10]), 64'(r.wait_time));
                if (flag !== r.event_occurred)
                    report("event_occurred", 64'(flag), 64'(r.event_occurred));
                if (data[83:42] !== r.total_weight)
                    report("total_weight", 64'(data[83:42]), 64'(r.total_weight));
                if (data[94:84] !== r.active_count)
                    report("active_count", 64'(data[94:84]), 64'(r.active_count));
                if (data[95] !== 1'b0)
                    report("pad bit", 64'(data[95]), 64'd0);
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // [9:0] leaf_index, [41:10] new_weight, [73:42] random_pick, [105:74] random_wait
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // [0] command
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // [9:0] event_index, [41:10] wait_time, [83:42] total_weight, [94:84] active_count
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // [0] event_occurred
    logic [0:0]            m_axis_tuser;

    sampler_scoreboard sb = new();
    int unsigned cycles   = 0;
    bit          no_gaps  = 0;   // toggled in stretches so both sides run flat out

    sum_tree_weighted_event_sampler_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("sum_tree_weighted_event_sampler_unit: mismatch");
            $finish;
        end
    end

    // Offer one item; inputs move on the falling edge, acceptance seen on the rising one.
    task send_item(logic cmd, logic [IDX_W-1:0] leaf, logic [31:0] weight,
                   logic [31:0] r_pick, logic [31:0] r_wait);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  = {6'd0, r_wait, r_pick, weight, leaf};
        s_axis_tuser  = cmd;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(cmd, leaf, weight, r_pick, r_wait);
        @(negedge i_clk);
    endtask

    task drain_results();
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    function logic [31:0] rand_weight();
        case ($urandom_range(0, 9))
            0, 1:    return 32'd0;
            2:       return 32'hFFFF_FFFF;
            3, 4:    return $urandom_range(1, 32'hFFFF);
            default: return $urandom;
        endcase
    endfunction

    function logic [31:0] rand_fraction();
        case ($urandom_range(0, 19))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // Result side: random stalls, checked on the rising edge.
    initial begin
        int stall;
        @(negedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata, m_axis_tuser[0]);
            @(negedge i_clk);
        end
    end

    initial begin
        logic [IDX_W-1:0] leaf;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty tree, extreme weights and fractions, zero r2, clearing a leaf.
        send_item(CMD_DRAW, '0, '0, 32'h8000_0000, 32'h8000_0000);
        send_item(CMD_SET, 10'd0, 32'hFFFF_FFFF, '0, '0);
        send_item(CMD_SET, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_DRAW, '0, '0, 32'h0000_0000, 32'hFFFF_FFFF);
        send_item(CMD_DRAW, '0, '0, 32'hFFFF_FFFF, 32'h0000_0001);
        send_item(CMD_DRAW, 10'h3FF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000);
        send_item(CMD_SET, 10'd512, 32'd1, '0, '0);
        send_item(CMD_SET, 10'd0, 32'd0, '0, '0);
        send_item(CMD_SET, 10'd0, 32'd0, '0, '0);
        send_item(CMD_DRAW, '0, '0, 32'h8000_0000, 32'h0000_0001);
        send_item(CMD_SET, 10'd1023, 32'd0, '0, '0);
        send_item(CMD_DRAW, '0, '0, 32'hFFFF_FFFF, 32'h0000_0000);
        send_item(CMD_SET, 10'd512, 32'd0, '0, '0);
        send_item(CMD_DRAW, '0, '0, 32'h1234_5678, 32'h0000_0000);
        send_item(CMD_SET, 10'd300, 32'd1, '0, '0);
        send_item(CMD_DRAW, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(CMD_DRAW, '0, '0, 32'hFFFF_FFFF, 32'h0000_0001);

        // Hold off until the block has gone quiet, then run random traffic.
        s_axis_tvalid = 1'b0;
        drain_results();
        @(negedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 200 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            // a small hot set of leaves, so weights get overwritten and cleared
            leaf = ($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 15))
                                               : IDX_W'($urandom);
            if ($urandom_range(0, 1) == 0)
                send_item(CMD_SET, leaf, rand_weight(), $urandom, $urandom);
            else
                send_item(CMD_DRAW, leaf, $urandom, rand_fraction(), rand_fraction());
        end
        s_axis_tvalid = 1'b0;

        drain_results();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("sum_tree_weighted_event_sampler_unit: match");
        else
            $display("sum_tree_weighted_event_sampler_unit: mismatch");
        $finish;
    end
endmodule
